### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sbsc_pkg.sv
// ----------------------------------------------------------------------------
// sbsc_pkg
// Widths, reset values and register indexes of the segment box slab clipper.
// ----------------------------------------------------------------------------
package sbsc_pkg;

    localparam int COORD_W           = 32;
    localparam int HALF_W            = 31;
    localparam int SPAN_W            = 16;
    localparam int FRAC_BITS_DEFAULT = 16;

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(65536);
    localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(1);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_HALF_X,
        CFG_HALF_Y,
        CFG_HALF_Z,
        CFG_MIN_SPAN
    } cfg_index_t;

endpackage

### hw/rtl/sbsc_div.sv
// ----------------------------------------------------------------------------
// sbsc_div
// Pipelined restoring divider: one quotient bit per stage, sign applied last.
// ----------------------------------------------------------------------------
module sbsc_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [NUM_W-1:0]        num,
    input  logic [DEN_W-1:0]        den,
    input  logic                    neg,
    output logic signed [NUM_W:0]   quo
);

    logic [DEN_W-1:0] rem_reg [NUM_W-1];
    logic [DEN_W-1:0] den_reg [NUM_W-1];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic             neg_reg [NUM_W];
    logic signed [NUM_W:0] quo_reg;

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++)
        begin : g_step
            logic [DEN_W-1:0] r_in;
            logic [DEN_W-1:0] d_in;
            logic [NUM_W-1:0] n_in;
            logic             s_in;
            logic [DEN_W:0]   trial;
            logic [DEN_W+1:0] diff;
            logic             ge;

            // Pick the operands of this step from the inputs or the previous stage.
            if (k == 0)
            begin : g_first
                assign r_in = '0;
                assign d_in = den;
                assign n_in = num;
                assign s_in = neg;
            end
            else
            begin : g_rest
                assign r_in = rem_reg[k-1];
                assign d_in = den_reg[k-1];
                assign n_in = nq_reg[k-1];
                assign s_in = neg_reg[k-1];
            end

            // Shift in the next numerator bit and try to subtract the divisor.
            assign trial = {r_in, n_in[NUM_W-1]};
            assign diff  = {1'b0, trial} - {2'b00, d_in};
            assign ge    = ~diff[DEN_W+1];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nq_reg[k]  <= {n_in[NUM_W-2:0], ge};
                    neg_reg[k] <= s_in;
                end
            end

            // The remainder and divisor are not needed after the last step.
            if (k < NUM_W - 1)
            begin : g_keep
                logic [DEN_W-1:0] rem_next;
                assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k] <= rem_next;
                        den_reg[k] <= d_in;
                    end
                end
            end
        end
    endgenerate

    // Apply the sign of the quotient.
    logic signed [NUM_W:0] quo_next;
    assign quo_next = neg_reg[NUM_W-1] ? -signed'({1'b0, nq_reg[NUM_W-1]})
                                       : signed'({1'b0, nq_reg[NUM_W-1]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

### hw/rtl/segment_box_slab_clip.sv
// ----------------------------------------------------------------------------
// segment_box_slab_clip
// Slab clipping of a segment against an origin-centred box, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  s_*       in         tvalid / tready    segment start and end points
//  m_*       out        tvalid / tready    hit flag and clipped start point
//  cfg_*     in         valid / ready      register index and write data
//
//  One item enters per cycle while m_tready does not stall; the pipeline is the
//  one-bit-per-stage dividers (32 + FRAC_BITS + 1 stages) plus six stages.
//  Reset clears the valid bits and loads the register reset values.
//  A stall on m_tready freezes the whole pipeline; s_tready follows it.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_box_slab_clip
    import sbsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x, start_y, start_z, stop_x, stop_y, stop_z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // clipped_x, clipped_y, clipped_z
    output logic [95:0]  m_tdata,
    // hit
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int NUM_W   = COORD_W + FRAC_BITS;
    localparam int DIV_LAT = NUM_W + 1;
    localparam int LO_W    = NUM_W / 2;
    localparam int HI_W    = NUM_W - LO_W;
    localparam int PROD_W  = COORD_W + NUM_W;
    localparam int SAT_BIT = COORD_W + 1 + FRAC_BITS;
    localparam int MAG_W   = COORD_W + 2;

    typedef struct packed {
        logic                    miss;
        logic [2:0]              mot;
        logic [2:0]              dneg;
        logic [2:0][COORD_W-1:0] ad;
        logic [2:0][COORD_W-1:0] s;
    } side_t;

    // Configuration registers.
    logic [HALF_W-1:0] half_x_reg, half_y_reg, half_z_reg;
    logic [SPAN_W-1:0] span_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_x_reg <= HALF_RESET;
            half_y_reg <= HALF_RESET;
            half_z_reg <= HALF_RESET;
            span_reg   <= SPAN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_HALF_X:   half_x_reg <= cfg_data[HALF_W-1:0];
                CFG_HALF_Y:   half_y_reg <= cfg_data[HALF_W-1:0];
                CFG_HALF_Z:   half_z_reg <= cfg_data[HALF_W-1:0];
                CFG_MIN_SPAN: span_reg   <= cfg_data[SPAN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Global advance: the pipeline moves unless the output item is held.
    logic en;
    logic o_valid_reg;
    assign en       = ~o_valid_reg | m_tready;
    assign s_tready = en;

    // Front stage: spans, face rejection, motion test and numerators.
    logic [HALF_W-1:0] half_ax [3];
    assign half_ax[0] = half_x_reg;
    assign half_ax[1] = half_y_reg;
    assign half_ax[2] = half_z_reg;

    side_t                   a_side_next;
    logic [2:0][COORD_W-1:0] nb_mag_next, ne_mag_next;
    logic [2:0]              nb_neg_next, ne_neg_next;

    always_comb
    begin
        logic signed [33:0] sv, ev, hv, eps, d, nb, ne, ad;
        logic               lt;
        a_side_next = '0;
        nb_mag_next = '0;
        ne_mag_next = '0;
        nb_neg_next = '0;
        ne_neg_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            sv  = {{2{s_tdata[32*i+31]}}, s_tdata[32*i +: 32]};
            ev  = {{2{s_tdata[32*i+127]}}, s_tdata[32*i+96 +: 32]};
            hv  = {3'b000, half_ax[i]};
            eps = {18'd0, span_reg};
            d   = ev - sv;
            lt  = sv < ev;
            if (lt)
            begin
                a_side_next.miss = a_side_next.miss | (sv > hv) | (ev < -hv);
                a_side_next.mot[i] = d > eps;
                nb = -hv - sv;
                ne = hv - sv;
            end
            else
            begin
                a_side_next.miss = a_side_next.miss | (ev > hv) | (sv < -hv);
                a_side_next.mot[i] = d < -eps;
                nb = sv - hv;
                ne = sv + hv;
            end
            ad = d[33] ? -d : d;
            a_side_next.dneg[i] = d[33];
            a_side_next.ad[i]   = ad[COORD_W-1:0];
            a_side_next.s[i]    = s_tdata[32*i +: 32];
            nb_neg_next[i] = nb[33];
            ne_neg_next[i] = ne[33];
            nb = nb[33] ? -nb : nb;
            ne = ne[33] ? -ne : ne;
            nb_mag_next[i] = nb[COORD_W-1:0];
            ne_mag_next[i] = ne[COORD_W-1:0];
        end
    end

    logic                    a_valid_reg;
    side_t                   a_side_reg;
    logic [2:0][COORD_W-1:0] a_nb_mag_reg, a_ne_mag_reg;
    logic [2:0]              a_nb_neg_reg, a_ne_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg   <= a_side_next;
            a_nb_mag_reg <= nb_mag_next;
            a_ne_mag_reg <= ne_mag_next;
            a_nb_neg_reg <= nb_neg_next;
            a_ne_neg_reg <= ne_neg_next;
        end
    end

    // Entry and exit parameters: two dividers per axis.
    logic signed [NUM_W:0] bt_q [3];
    logic signed [NUM_W:0] et_q [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_axis
            sbsc_div #(.NUM_W(NUM_W), .DEN_W(COORD_W)) u_div_entry (
                .clk (clk),
                .en  (en),
                .num ({a_nb_mag_reg[g], {FRAC_BITS{1'b0}}}),
                .den (a_side_reg.ad[g]),
                .neg (a_nb_neg_reg[g]),
                .quo (bt_q[g])
            );
            sbsc_div #(.NUM_W(NUM_W), .DEN_W(COORD_W)) u_div_exit (
                .clk (clk),
                .en  (en),
                .num ({a_ne_mag_reg[g], {FRAC_BITS{1'b0}}}),
                .den (a_side_reg.ad[g]),
                .neg (a_ne_neg_reg[g]),
                .quo (et_q[g])
            );
        end
    endgenerate

    // Side information travels alongside the dividers.
    side_t side_reg  [DIV_LAT];
    logic  dvld_reg  [DIV_LAT];

    generate
        for (g = 0; g < DIV_LAT; g++)
        begin : g_delay
            side_t side_in;
            logic  vld_in;
            if (g == 0)
            begin : g_first
                assign side_in = a_side_reg;
                assign vld_in  = a_valid_reg;
            end
            else
            begin : g_rest
                assign side_in = side_reg[g-1];
                assign vld_in  = dvld_reg[g-1];
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dvld_reg[g] <= 1'b0;
                end
                else if (en)
                begin
                    dvld_reg[g] <= vld_in;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[g] <= side_in;
                end
            end
        end
    endgenerate

    // Largest entry and smallest exit over the moving axes.
    side_t                 div_side;
    logic signed [NUM_W:0] entry_next, exit_next;
    assign div_side = side_reg[DIV_LAT-1];

    always_comb
    begin
        logic seen;
        seen       = 1'b0;
        entry_next = '0;
        exit_next  = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (div_side.mot[i])
            begin
                if (!seen || bt_q[i] > entry_next)
                    entry_next = bt_q[i];
                if (!seen || et_q[i] < exit_next)
                    exit_next = et_q[i];
                seen = 1'b1;
            end
        end
    end

    logic                  r_valid_reg;
    side_t                 r_side_reg;
    logic signed [NUM_W:0] r_entry_reg, r_exit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r_valid_reg <= dvld_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_side_reg  <= div_side;
            r_entry_reg <= entry_next;
            r_exit_reg  <= exit_next;
        end
    end

    // Miss decision and choice of the motion parameter.
    logic                  r_any;
    logic                  t_miss_next;
    logic signed [NUM_W:0] t_sel;
    logic [NUM_W:0]        t_abs;
    assign r_any       = |r_side_reg.mot;
    assign t_miss_next = r_side_reg.miss | (r_any & (r_exit_reg < r_entry_reg));
    assign t_sel       = (r_exit_reg > 0) ? r_entry_reg : r_exit_reg;
    assign t_abs       = t_sel[NUM_W] ? -t_sel : t_sel;

    logic                    t_valid_reg;
    side_t                   t_side_reg;
    logic                    t_miss_reg, t_any_reg, t_neg_reg;
    logic [NUM_W-1:0]        t_abs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_side_reg <= r_side_reg;
            t_miss_reg <= t_miss_next;
            t_any_reg  <= r_any;
            t_neg_reg  <= t_sel[NUM_W];
            t_abs_reg  <= t_abs[NUM_W-1:0];
        end
    end

    // Partial products of |span| by |t|, split in two halves of t.
    logic [2:0][COORD_W+LO_W-1:0] pp_lo_next;
    logic [2:0][COORD_W+HI_W-1:0] pp_hi_next;
    logic [2:0]                   mneg_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pp_lo_next[i] = {{LO_W{1'b0}}, t_side_reg.ad[i]}
                          * {{COORD_W{1'b0}}, t_abs_reg[LO_W-1:0]};
            pp_hi_next[i] = {{HI_W{1'b0}}, t_side_reg.ad[i]}
                          * {{COORD_W{1'b0}}, t_abs_reg[NUM_W-1:LO_W]};
            mneg_next[i]  = t_side_reg.dneg[i] ^ t_neg_reg;
        end
    end

    logic                         m_valid_reg;
    logic [2:0][COORD_W+LO_W-1:0] m_pp_lo_reg;
    logic [2:0][COORD_W+HI_W-1:0] m_pp_hi_reg;
    logic [2:0]                   m_neg_reg;
    logic                         m_miss_reg, m_any_reg;
    logic [2:0][COORD_W-1:0]      m_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= t_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_pp_lo_reg <= pp_lo_next;
            m_pp_hi_reg <= pp_hi_next;
            m_neg_reg   <= mneg_next;
            m_miss_reg  <= t_miss_reg;
            m_any_reg   <= t_any_reg;
            m_s_reg     <= t_side_reg.s;
        end
    end

    // Sum the partial products, drop the fraction and clamp large motions.
    logic [2:0][MAG_W-1:0] mag_next;

    always_comb
    begin
        logic [PROD_W-1:0] prod;
        for (int i = 0; i < 3; i++)
        begin
            prod = {m_pp_hi_reg[i], {LO_W{1'b0}}}
                 + {{(PROD_W-COORD_W-LO_W){1'b0}}, m_pp_lo_reg[i]};
            if (|prod[PROD_W-1:SAT_BIT])
                mag_next[i] = MAG_W'(1) << (COORD_W + 1);
            else
                mag_next[i] = {1'b0, prod[SAT_BIT-1:FRAC_BITS]};
        end
    end

    logic                    p_valid_reg;
    logic [2:0][MAG_W-1:0]   p_mag_reg;
    logic [2:0]              p_neg_reg;
    logic                    p_miss_reg, p_any_reg;
    logic [2:0][COORD_W-1:0] p_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_mag_reg  <= mag_next;
            p_neg_reg  <= m_neg_reg;
            p_miss_reg <= m_miss_reg;
            p_any_reg  <= m_any_reg;
            p_s_reg    <= m_s_reg;
        end
    end

    // Move the start point with saturation and form the result item.
    logic [95:0] o_data_next;

    always_comb
    begin
        logic signed [MAG_W+1:0] sx, r;
        logic [COORD_W-1:0]      sat;
        for (int i = 0; i < 3; i++)
        begin
            sx = {{(MAG_W+2-COORD_W){p_s_reg[i][COORD_W-1]}}, p_s_reg[i]};
            if (p_neg_reg[i])
                r = sx - {2'b00, p_mag_reg[i]};
            else
                r = sx + {2'b00, p_mag_reg[i]};
            if (r[MAG_W+1:COORD_W-1] == '0 || r[MAG_W+1:COORD_W-1] == '1)
                sat = r[COORD_W-1:0];
            else
                sat = r[MAG_W+1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                 : {1'b0, {(COORD_W-1){1'b1}}};
            if (p_miss_reg)
                o_data_next[32*i +: 32] = '0;
            else if (p_any_reg)
                o_data_next[32*i +: 32] = sat;
            else
                o_data_next[32*i +: 32] = p_s_reg[i];
        end
    end

    logic [95:0] o_data_reg;
    logic        o_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_data_reg <= o_data_next;
            o_hit_reg  <= ~p_miss_reg;
        end
    end

    assign m_tvalid   = o_valid_reg;
    assign m_tdata    = o_data_reg;
    assign m_tuser[0] = o_hit_reg;

    // A rejected segment carries a zero point.
    `ASSERT_IMPLY(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "miss with nonzero point")
    // Input is refused only while a finished item waits at the output.
    `ASSERT_IMPLY(a_ready_stall, !s_tready, m_tvalid && !m_tready, "input refused without stall")
    // A write to the x half-extent lands in the next cycle.
    `ASSERT_NEXT(a_cfg_half_x, cfg_valid && cfg_index == CFG_HALF_X, half_x_reg == $past(cfg_data[30:0]), "half_x write lost")

endmodule

### bench/tb_segment_box_slab_clip.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_box_slab_clip
// Self-checking bench for the segment box slab clipper. Segments are sent
// through the stream input while the output side stalls at random. Every
// result is checked field by field against a behavioural slab-clip model.
// ----------------------------------------------------------------------------

// Holds the expected clip results in order and checks the block's output.
class clip_scoreboard;
    typedef struct packed {
        logic        hit;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
    } clip_result_t;

    clip_result_t pending_clips[$];
    int           errors;
    int           checked;
    int           hits;

    // Register copies.
    longint half_ext[3];
    longint span_floor;

    function new();
        half_ext[0] = 65536;
        half_ext[1] = 65536;
        half_ext[2] = 65536;
        span_floor  = 1;
        errors      = 0;
        checked     = 0;
        hits        = 0;
    endfunction

    function void set_reg(sbsc_pkg::cfg_index_t idx, logic [31:0] val);
        if (idx == sbsc_pkg::CFG_MIN_SPAN)
            span_floor = longint'(val[15:0]);
        else
            half_ext[int'(idx)] = longint'(val[30:0]);
    endfunction

    // Truncating fixed-point division, as in the block.
    function longint param_div(longint num, longint den);
        longint q;
        longint an;
        longint ad;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q  = (an << 16) / ad;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    // Moves one coordinate along the span by t, with saturation.
    function logic [31:0] advance(longint s, longint d, longint t);
        longint unsigned ad;
        longint unsigned at;
        longint unsigned mag;
        longint unsigned lim;
        longint          r;
        logic            neg;
        ad  = (d < 0) ? -d : d;
        at  = (t < 0) ? -t : t;
        neg = (d < 0) != (t < 0);
        lim = 64'd1 << 49;
        if (at != 0 && ad > (lim - 1) / at)
            mag = 64'd1 << 33;
        else
            mag = (ad * at) >> 16;
        r = neg ? s - longint'(mag) : s + longint'(mag);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // Notes an accepted segment and queues its expected result.
    function void note_segment(logic [191:0] seg);
        longint       s[3];
        longint       e[3];
        longint       d[3];
        longint       h;
        longint       bt;
        longint       et;
        longint       entry;
        longint       exit_t;
        longint       t;
        logic         moving;
        logic         miss;
        clip_result_t res;
        entry  = 0;
        exit_t = 0;
        moving = 0;
        miss   = 0;
        for (int i = 0; i < 3; i++)
        begin
            s[i] = longint'($signed(seg[32*i +: 32]));
            e[i] = longint'($signed(seg[32*(i+3) +: 32]));
        end
        for (int i = 0; i < 3; i++)
        begin
            h    = half_ext[i];
            d[i] = e[i] - s[i];
            if (!miss)
            begin
                if (s[i] < e[i])
                begin
                    if (s[i] > h || e[i] < -h)
                        miss = 1;
                    else if (d[i] > span_floor)
                    begin
                        bt = param_div(-h - s[i], d[i]);
                        et = param_div(h - s[i], d[i]);
                        if (!moving || bt > entry) entry = bt;
                        if (!moving || et < exit_t) exit_t = et;
                        moving = 1;
                    end
                end
                else
                begin
                    if (e[i] > h || s[i] < -h)
                        miss = 1;
                    else if (d[i] < -span_floor)
                    begin
                        bt = param_div(h - s[i], d[i]);
                        et = param_div(-h - s[i], d[i]);
                        if (!moving || bt > entry) entry = bt;
                        if (!moving || et < exit_t) exit_t = et;
                        moving = 1;
                    end
                end
            end
        end
        if (!miss && moving && exit_t < entry)
            miss = 1;
        if (miss)
            res = '0;
        else
        begin
            res.hit = 1'b1;
            res.cx  = s[0][31:0];
            res.cy  = s[1][31:0];
            res.cz  = s[2][31:0];
            if (moving)
            begin
                t      = (exit_t > 0) ? entry : exit_t;
                res.cx = advance(s[0], d[0], t);
                res.cy = advance(s[1], d[1], t);
                res.cz = advance(s[2], d[2], t);
            end
        end
        pending_clips.push_back(res);
    endfunction

    // Checks one accepted result against the oldest expectation.
    function void check_result(logic hit, logic [95:0] clip);
        clip_result_t want;
        if (pending_clips.size() == 0)
        begin
            $display("%0t: unexpected result hit=%0b data=%h", $time, hit, clip);
            errors++;
            return;
        end
        want = pending_clips.pop_front();
        checked++;
        if (hit) hits++;
        if (hit !== want.hit)
        begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
            errors++;
        end
        if (clip[31:0] !== want.cx)
        begin
            $display("%0t: clipped_x expected %h actual %h", $time, want.cx, clip[31:0]);
            errors++;
        end
        if (clip[63:32] !== want.cy)
        begin
            $display("%0t: clipped_y expected %h actual %h", $time, want.cy, clip[63:32]);
            errors++;
        end
        if (clip[95:64] !== want.cz)
        begin
            $display("%0t: clipped_z expected %h actual %h", $time, want.cz, clip[95:64]);
            errors++;
        end
    endfunction
endclass

module tb_segment_box_slab_clip;
    import sbsc_pkg::*;

    localparam int LATENCY     = 16 + 39;
    localparam int CYCLE_LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // start_x, start_y, start_z, stop_x, stop_y, stop_z
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // clipped_x, clipped_y, clipped_z
    logic [95:0]  m_tdata;
    // hit
    logic [0:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    clip_scoreboard clips;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  cycles;
    int  sent;

    segment_box_slab_clip dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb_segment_box_slab_clip: FAIL");
                $finish;
            end
        end
    end

    // Output side: random stall, plus a long hold-off when asked.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                clips.check_result(m_tuser[0], m_tdata);
            m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Writes one register while the block is idle, then waits a clock with cfg_valid low.
    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        clips.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one segment and waits until it is taken. Valid stays high so
    // that the next item can follow directly; idle cycles and drain() lower it.
    task automatic send_segment(logic [191:0] seg);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seg;
        do @(posedge clk); while (!s_tready);
        clips.note_segment(seg);
        sent++;
    endtask

    // Stops offering items and waits for every result to come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (clips.pending_clips.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic logic [31:0] coord(logic [31:0] h);
        logic [31:0] r;
        case ($urandom_range(5))
            0: r = $urandom;
            1: r = h;
            2: r = -h;
            3: r = $urandom_range(4) - 2;
            default: r = $signed($urandom) >>> $urandom_range(30, 8);
        endcase
        return r;
    endfunction

    function automatic logic [191:0] rand_segment();
        logic [191:0] seg;
        for (int i = 0; i < 3; i++)
        begin
            seg[32*i +: 32]     = coord(32'(clips.half_ext[i]));
            seg[32*(i+3) +: 32] = ($urandom_range(7) == 0) ? seg[32*i +: 32]
                                                          : coord(32'(clips.half_ext[i]));
        end
        return seg;
    endfunction

    task automatic random_phase(int n);
        repeat (n) send_segment(rand_segment());
    endtask

    // Stimulus.
    initial
    begin
        logic [31:0] ext[6];
        clips         = new();
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_HALF_X;
        cfg_data      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off      = 1'b0;
        sent          = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases: extremes, degenerate spans, misses, hits.
        ext[0] = 32'h7FFF_FFFF;
        ext[1] = 32'h8000_0000;
        ext[2] = 32'h0;
        ext[3] = 32'h0001_0000;
        ext[4] = 32'hFFFF_0000;
        ext[5] = 32'h0000_8000;
        send_segment({6{32'h0}});
        send_segment({ext[4], ext[4], ext[4], ext[3], ext[3], ext[3]});
        send_segment({ext[0], ext[0], ext[0], ext[1], ext[1], ext[1]});
        send_segment({ext[1], ext[1], ext[1], ext[0], ext[0], ext[0]});
        send_segment({ext[2], ext[2], 32'h0003_0000, ext[2], ext[2], 32'hFFFD_0000});
        send_segment({ext[5], ext[5], ext[5], ext[5], ext[5], ext[5]});
        send_segment({ext[2], ext[2], 32'h0000_0001, ext[2], ext[2], ext[2]});
        send_segment({ext[2], ext[2], 32'h0002_0000, ext[2], ext[2], 32'h0003_0000});
        send_segment({ext[2], 32'h0002_0000, ext[5], ext[2], 32'hFFFE_0000, ext[2]});
        send_segment({ext[3], ext[3], ext[3], ext[4], ext[4], ext[4]});
        send_segment({32'h0002_0000, ext[2], ext[2], ext[2], 32'h0002_0000, ext[2]});
        send_segment({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        drain();

        // Sender idles rarely, receiver often; then the reverse.
        write_reg(CFG_HALF_X, 32'h7FFF_FFFF);
        write_reg(CFG_HALF_Y, 32'h0);
        write_reg(CFG_HALF_Z, 32'h0010_0000);
        write_reg(CFG_MIN_SPAN, 32'hFFFF);
        send_idle_pct = 27;
        recv_idle_pct = 69;
        random_phase(250);
        drain();

        write_reg(CFG_HALF_X, 32'h0000_4000);
        write_reg(CFG_HALF_Y, 32'h7FFF_FFFF);
        write_reg(CFG_HALF_Z, 32'h0040_0000);
        write_reg(CFG_MIN_SPAN, 32'h0);
        send_idle_pct = 69;
        recv_idle_pct = 27;
        random_phase(250);
        drain();

        // Full rate, with one long output hold-off so the input backs up.
        write_reg(CFG_HALF_X, 32'h0001_0000);
        write_reg(CFG_HALF_Y, 32'h0001_0000);
        write_reg(CFG_HALF_Z, 32'h0001_0000);
        write_reg(CFG_MIN_SPAN, 32'h1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (3 * LATENCY) @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(440);
        join
        drain();

        $display("Sent %0d segments, checked %0d results, %0d hits.",
                 sent, clips.checked, clips.hits);
        $display("Four register settings, including the extremes, with stalls on both sides.");
        if (clips.errors == 0)
            $display("tb_segment_box_slab_clip: PASS");
        else
            $display("tb_segment_box_slab_clip: FAIL");
        $finish;
    end
endmodule
